### rtl/tpgc_pkg.sv
// ----------------------------------------------------------------------------
// tpgc_pkg: shared types and constants of the two-player game clock
// Command and result payloads, mode, direction, register and sequencer codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tpgc_pkg;

	// Fixed field widths.
	localparam int TIME_W   = 28;   // signed time on the result channel
	localparam int CFG_W    = 27;   // main time and bonus registers
	localparam int PER_W    = 8;    // byo-yomi period count
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 5;

	// Shared datapath: main + bonus * periods fits in 36 bits, plus a sign.
	localparam int ACC_W    = 37;
	localparam int DIV_BITS = 27;   // a non-negative time is below 2**27
	localparam int MUL_BITS = 8;    // multiplier digits for the shift-add passes
	localparam int STEP_W   = $clog2(DIV_BITS);

	localparam longint unsigned DAY_MS = 64'd86400000;

	localparam logic [CFG_W-1:0] MAIN_RESET = 27'd300000;

	typedef enum logic [2:0] {
		CMD_TICK,
		CMD_START,
		CMD_SWITCH,
		CMD_STOP,
		CMD_RESET
	} cmd_code_t;

	typedef enum logic [2:0] {
		MODE_SUDDEN,
		MODE_FISCHER,
		MODE_BRONSTEIN,
		MODE_HOURGLASS,
		MODE_BYOYOMI
	} mode_t;

	typedef enum logic [1:0] {
		DIR_PAUSED,
		DIR_DOWN,
		DIR_UP
	} dir_t;

	typedef enum logic [1:0] {
		RUN_NONE,
		RUN_LEFT,
		RUN_RIGHT
	} run_t;

	typedef enum logic [2:0] {
		REG_CLOCK_MODE,
		REG_MAIN_LEFT,
		REG_MAIN_RIGHT,
		REG_BONUS_LEFT,
		REG_BONUS_RIGHT,
		REG_PERIODS_LEFT,
		REG_PERIODS_RIGHT
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_TICK,
		ST_INIT_LOAD,
		ST_INIT_MUL,
		ST_INIT_SAT,
		ST_SW_CHECK,
		ST_SW_ADD,
		ST_SW_CAP,
		ST_DIV,
		ST_DIV_CHK,
		ST_RES_MUL,
		ST_RES_SAT,
		ST_SW_FINISH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0] command;
		logic       side;
	} cmd_t;

	typedef struct packed {
		logic signed [TIME_W-1:0] left_time;
		logic signed [TIME_W-1:0] right_time;
		logic [1:0]               running_side;
		logic                     left_flagged;
		logic                     right_flagged;
		logic                     state_changed;
	} res_t;

endpackage

`default_nettype wire

### rtl/two_player_game_clock_core.sv
// ----------------------------------------------------------------------------
// two_player_game_clock_core: two-sided game clock
// Sudden death, Fischer, Bronstein, hourglass and byo-yomi timing on one
// shared adder driven by a small sequencer.
// ----------------------------------------------------------------------------
//
// Usage
//   Commands arrive on the cmd channel (valid/ready): tick one millisecond,
//   start a side, switch sides, stop, or reset. Every accepted command gives
//   exactly one result transfer on the res channel (valid/ready) carrying both
//   signed times, the running side, the two flags and a state-changed bit.
//   Configuration lives behind an APB-style port at byte address 4*index;
//   pready is tied high and registers are read back as written. Registers
//   are meant to be written only while the clock has no command in flight.
//
// Sequencing
//   The block works on one command at a time and takes no new command until
//   the result of the previous one is in the output register. The byo-yomi
//   switch runs the 27-step restoring division of the current time by the
//   period length, followed, while periods remain, by an 8-step shift-add
//   multiply, both on the same 37-bit adder; reset runs two 8-step
//   multiplies, one per side.
//
// Reset and stalls
//   arst_n clears the clock: both times zero, both sides paused, nothing
//   running, Bronstein caps zero, registers to their documented defaults.
//   The output register holds one result; a new command may be accepted
//   while it waits, and the sequencer parks in its final state until the
//   receiver takes the old result, so no result is dropped or overwritten.
//
`default_nettype none

module two_player_game_clock_core #(
	parameter int TIME_BITS = 28
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// command channel
	input  wire logic                          cmd_valid,
	output logic                               cmd_ready,
	input  wire tpgc_pkg::cmd_t                cmd,
	// result channel
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output tpgc_pkg::res_t                     res,
	// configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tpgc_pkg::APB_AW-1:0]   paddr,
	input  wire logic [tpgc_pkg::APB_DW-1:0]   pwdata,
	output logic      [tpgc_pkg::APB_DW-1:0]   prdata,
	output logic                               pready
);

	localparam int AW = tpgc_pkg::ACC_W;
	localparam int DW = tpgc_pkg::DIV_BITS;
	localparam int MW = tpgc_pkg::MUL_BITS;
	localparam int SW = tpgc_pkg::STEP_W;
	localparam int CW = tpgc_pkg::CFG_W;
	localparam int PW = tpgc_pkg::PER_W;
	localparam int TW = tpgc_pkg::TIME_W;
	localparam int BW = tpgc_pkg::APB_DW;

	// Saturation limit: one day, or the largest positive value of a
	// TIME_BITS-wide signed word when that is smaller.
	localparam longint unsigned TOP_VAL = (64'd1 << (TIME_BITS - 1)) - 64'd1;
	localparam longint unsigned SAT_VAL =
		(TOP_VAL < tpgc_pkg::DAY_MS) ? TOP_VAL : tpgc_pkg::DAY_MS;
	// Stored times never leave plus or minus SAT_VAL.
	localparam int CNT_W = $clog2(SAT_VAL + 1) + 1;

	localparam logic signed [AW-1:0] SAT_POS = AW'(SAT_VAL);
	localparam logic signed [AW-1:0] SAT_NEG = -AW'(SAT_VAL);

	function automatic logic signed [CNT_W-1:0] sat_f(input logic signed [AW-1:0] v);
		logic signed [CNT_W-1:0] r;
		if (v > SAT_POS) begin
			r = SAT_POS[CNT_W-1:0];
		end else if (v < SAT_NEG) begin
			r = SAT_NEG[CNT_W-1:0];
		end else begin
			r = v[CNT_W-1:0];
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [2:0]    mode_q;
	logic [CW-1:0] main_q    [2];
	logic [CW-1:0] bonus_q   [2];
	logic [PW-1:0] periods_q [2];
	logic          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 3'(tpgc_pkg::MODE_SUDDEN);
			main_q[0]    <= tpgc_pkg::MAIN_RESET;
			main_q[1]    <= tpgc_pkg::MAIN_RESET;
			bonus_q[0]   <= '0;
			bonus_q[1]   <= '0;
			periods_q[0] <= '0;
			periods_q[1] <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				tpgc_pkg::REG_CLOCK_MODE:    mode_q       <= pwdata[2:0];
				tpgc_pkg::REG_MAIN_LEFT:     main_q[0]    <= pwdata[CW-1:0];
				tpgc_pkg::REG_MAIN_RIGHT:    main_q[1]    <= pwdata[CW-1:0];
				tpgc_pkg::REG_BONUS_LEFT:    bonus_q[0]   <= pwdata[CW-1:0];
				tpgc_pkg::REG_BONUS_RIGHT:   bonus_q[1]   <= pwdata[CW-1:0];
				tpgc_pkg::REG_PERIODS_LEFT:  periods_q[0] <= pwdata[PW-1:0];
				tpgc_pkg::REG_PERIODS_RIGHT: periods_q[1] <= pwdata[PW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[4:2])
			tpgc_pkg::REG_CLOCK_MODE:    prdata = BW'(mode_q);
			tpgc_pkg::REG_MAIN_LEFT:     prdata = BW'(main_q[0]);
			tpgc_pkg::REG_MAIN_RIGHT:    prdata = BW'(main_q[1]);
			tpgc_pkg::REG_BONUS_LEFT:    prdata = BW'(bonus_q[0]);
			tpgc_pkg::REG_BONUS_RIGHT:   prdata = BW'(bonus_q[1]);
			tpgc_pkg::REG_PERIODS_LEFT:  prdata = BW'(periods_q[0]);
			tpgc_pkg::REG_PERIODS_RIGHT: prdata = BW'(periods_q[1]);
			default:                     prdata = '0;
		endcase
	end

	// Mode codes above byo-yomi behave as sudden death.
	tpgc_pkg::mode_t mode_eff;
	assign mode_eff = (mode_q > 3'(tpgc_pkg::MODE_BYOYOMI)) ? tpgc_pkg::MODE_SUDDEN
		: tpgc_pkg::mode_t'(mode_q);

	// ------------------------------------------------------------------
	// Clock state
	// ------------------------------------------------------------------
	logic signed [CNT_W-1:0] count_q [2];
	logic signed [CNT_W-1:0] cap_q   [2];
	tpgc_pkg::dir_t          dir_q   [2];
	tpgc_pkg::run_t          marker_q;
	logic                    changed_q;

	// Sequencer and scratch registers
	tpgc_pkg::state_t        state_q, state_d;
	tpgc_pkg::cmd_t          cmd_q;
	logic                    sel_q;       // side being worked on
	logic [SW-1:0]           step_q;
	logic signed [AW-1:0]    acc_q;
	logic signed [AW-1:0]    mcand_q;
	logic [MW-1:0]           mplier_q;
	logic [DW:0]             rem_q;
	logic [DW-1:0]           quo_q;
	logic signed [CNT_W-1:0] tmp_q;

	tpgc_pkg::res_t          res_q;
	logic                    res_valid_q;

	// Derived values for the side under work.
	logic signed [CNT_W-1:0] cur;
	logic                    cur_neg;
	logic [CW-1:0]           inc;
	logic [DW:0]             div_shift;
	logic                    quo_lt;
	logic                    act_right;
	logic                    out_go;
	logic [MW-1:0]           init_mult;

	assign cur       = count_q[sel_q];
	assign cur_neg   = cur[CNT_W-1];
	assign inc       = bonus_q[sel_q];
	assign div_shift = {rem_q[DW-1:0], quo_q[DW-1]};
	assign quo_lt    = quo_q < DW'(periods_q[sel_q]);
	assign act_right = (marker_q == tpgc_pkg::RUN_RIGHT);
	assign out_go    = !res_valid_q || res_ready;

	// Multiplier for the initial time: the period count in byo-yomi, one
	// increment in Fischer and Bronstein, nothing otherwise.
	always_comb begin
		case (mode_eff)
			tpgc_pkg::MODE_BYOYOMI:   init_mult = periods_q[sel_q];
			tpgc_pkg::MODE_FISCHER,
			tpgc_pkg::MODE_BRONSTEIN: init_mult = MW'(1);
			default:                  init_mult = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Shared adder: ticks, increments, division trials and shift-add steps
	// ------------------------------------------------------------------
	logic signed [AW-1:0] alu_a, alu_b, alu_sum;
	logic                 alu_sub;
	logic signed [CNT_W-1:0] sum_sat, acc_sat;

	always_comb begin
		alu_sub = 1'b0;
		alu_a   = acc_q;
		alu_b   = mcand_q;
		unique case (state_q)
			tpgc_pkg::ST_TICK: begin
				alu_a   = AW'(cur);
				alu_b   = AW'(1);
				alu_sub = (dir_q[sel_q] == tpgc_pkg::DIR_DOWN);
			end
			tpgc_pkg::ST_SW_ADD: begin
				alu_a = AW'(cur);
				alu_b = AW'(inc);
			end
			tpgc_pkg::ST_DIV: begin
				alu_a   = AW'(div_shift);
				alu_b   = AW'(inc);
				alu_sub = 1'b1;
			end
			default: begin
				alu_a = acc_q;
				alu_b = mcand_q;
			end
		endcase
	end

	assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);
	assign sum_sat = sat_f(alu_sum);
	assign acc_sat = sat_f(acc_q);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpgc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		unique case (state_q)
			tpgc_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					state_d = tpgc_pkg::ST_DECODE;
				end
			end
			tpgc_pkg::ST_DECODE: begin
				unique case (cmd_q.command)
					tpgc_pkg::CMD_TICK:   state_d = tpgc_pkg::ST_TICK;
					tpgc_pkg::CMD_START: begin
						// A start on the idle side of a running clock is a switch.
						if (marker_q != tpgc_pkg::RUN_NONE && act_right != cmd_q.side) begin
							state_d = tpgc_pkg::ST_SW_CHECK;
						end else begin
							state_d = tpgc_pkg::ST_DONE;
						end
					end
					tpgc_pkg::CMD_SWITCH: begin
						state_d = (marker_q != tpgc_pkg::RUN_NONE) ? tpgc_pkg::ST_SW_CHECK
							: tpgc_pkg::ST_DONE;
					end
					tpgc_pkg::CMD_RESET:  state_d = tpgc_pkg::ST_INIT_LOAD;
					default:              state_d = tpgc_pkg::ST_DONE;
				endcase
			end
			tpgc_pkg::ST_TICK: begin
				state_d = sel_q ? tpgc_pkg::ST_DONE : tpgc_pkg::ST_TICK;
			end
			tpgc_pkg::ST_INIT_LOAD: state_d = tpgc_pkg::ST_INIT_MUL;
			tpgc_pkg::ST_INIT_MUL: begin
				if (step_q == SW'(MW - 1)) begin
					state_d = tpgc_pkg::ST_INIT_SAT;
				end
			end
			tpgc_pkg::ST_INIT_SAT: begin
				state_d = sel_q ? tpgc_pkg::ST_DONE : tpgc_pkg::ST_INIT_LOAD;
			end
			tpgc_pkg::ST_SW_CHECK: begin
				// A flagged side gets no bonus; hourglass sends the mover upward.
				if (cur_neg || mode_eff == tpgc_pkg::MODE_HOURGLASS) begin
					state_d = tpgc_pkg::ST_SW_FINISH;
				end else if (mode_eff == tpgc_pkg::MODE_FISCHER
						|| mode_eff == tpgc_pkg::MODE_BRONSTEIN) begin
					state_d = tpgc_pkg::ST_SW_ADD;
				end else if (mode_eff == tpgc_pkg::MODE_BYOYOMI && inc != '0) begin
					state_d = tpgc_pkg::ST_DIV;
				end else begin
					state_d = tpgc_pkg::ST_SW_FINISH;
				end
			end
			tpgc_pkg::ST_SW_ADD: begin
				state_d = (mode_eff == tpgc_pkg::MODE_BRONSTEIN) ? tpgc_pkg::ST_SW_CAP
					: tpgc_pkg::ST_SW_FINISH;
			end
			tpgc_pkg::ST_SW_CAP: state_d = tpgc_pkg::ST_SW_FINISH;
			tpgc_pkg::ST_DIV: begin
				if (step_q == SW'(DW - 1)) begin
					state_d = tpgc_pkg::ST_DIV_CHK;
				end
			end
			tpgc_pkg::ST_DIV_CHK: begin
				state_d = quo_lt ? tpgc_pkg::ST_RES_MUL : tpgc_pkg::ST_SW_FINISH;
			end
			tpgc_pkg::ST_RES_MUL: begin
				if (step_q == SW'(MW - 1)) begin
					state_d = tpgc_pkg::ST_RES_SAT;
				end
			end
			tpgc_pkg::ST_RES_SAT:   state_d = tpgc_pkg::ST_SW_FINISH;
			tpgc_pkg::ST_SW_FINISH: state_d = tpgc_pkg::ST_DONE;
			tpgc_pkg::ST_DONE: begin
				if (out_go) begin
					state_d = tpgc_pkg::ST_IDLE;
				end
			end
			default: state_d = tpgc_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Clock state updates
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q[0] <= '0;
			count_q[1] <= '0;
			cap_q[0]   <= '0;
			cap_q[1]   <= '0;
			dir_q[0]   <= tpgc_pkg::DIR_PAUSED;
			dir_q[1]   <= tpgc_pkg::DIR_PAUSED;
			marker_q   <= tpgc_pkg::RUN_NONE;
			changed_q  <= 1'b0;
		end else begin
			unique case (state_q)
				tpgc_pkg::ST_IDLE: begin
					if (cmd_valid) begin
						changed_q <= 1'b0;
					end
				end
				tpgc_pkg::ST_DECODE: begin
					unique case (cmd_q.command)
						tpgc_pkg::CMD_START: begin
							if (marker_q != tpgc_pkg::RUN_NONE) begin
								changed_q <= (act_right != cmd_q.side);
							end else begin
								// Start from rest; in hourglass the waiting side
								// counts up unless it has already flagged.
								if (mode_eff == tpgc_pkg::MODE_HOURGLASS
										&& !count_q[!cmd_q.side][CNT_W-1]) begin
									dir_q[!cmd_q.side] <= tpgc_pkg::DIR_UP;
								end
								dir_q[cmd_q.side] <= tpgc_pkg::DIR_DOWN;
								marker_q  <= cmd_q.side ? tpgc_pkg::RUN_RIGHT
									: tpgc_pkg::RUN_LEFT;
								changed_q <= 1'b1;
							end
						end
						tpgc_pkg::CMD_SWITCH: begin
							changed_q <= (marker_q != tpgc_pkg::RUN_NONE);
						end
						tpgc_pkg::CMD_STOP: begin
							if (marker_q != tpgc_pkg::RUN_NONE) begin
								dir_q[0]  <= tpgc_pkg::DIR_PAUSED;
								dir_q[1]  <= tpgc_pkg::DIR_PAUSED;
								marker_q  <= tpgc_pkg::RUN_NONE;
								changed_q <= 1'b1;
							end
						end
						tpgc_pkg::CMD_RESET: begin
							dir_q[0]  <= tpgc_pkg::DIR_PAUSED;
							dir_q[1]  <= tpgc_pkg::DIR_PAUSED;
							marker_q  <= tpgc_pkg::RUN_NONE;
							changed_q <= 1'b1;
						end
						default: ;
					endcase
				end
				tpgc_pkg::ST_TICK: begin
					if (dir_q[sel_q] != tpgc_pkg::DIR_PAUSED) begin
						count_q[sel_q] <= sum_sat;
					end
				end
				tpgc_pkg::ST_INIT_SAT: begin
					count_q[sel_q] <= acc_sat;
					if (mode_eff == tpgc_pkg::MODE_BRONSTEIN) begin
						cap_q[sel_q] <= acc_sat;
					end
				end
				tpgc_pkg::ST_SW_CHECK: begin
					dir_q[sel_q] <= (mode_eff == tpgc_pkg::MODE_HOURGLASS && !cur_neg)
						? tpgc_pkg::DIR_UP : tpgc_pkg::DIR_PAUSED;
				end
				tpgc_pkg::ST_SW_ADD: begin
					if (mode_eff != tpgc_pkg::MODE_BRONSTEIN) begin
						count_q[sel_q] <= sum_sat;
					end
				end
				tpgc_pkg::ST_SW_CAP: begin
					// Bronstein never lifts a time above its running cap.
					if (tmp_q > cap_q[sel_q]) begin
						count_q[sel_q] <= cap_q[sel_q];
					end else begin
						count_q[sel_q] <= tmp_q;
						cap_q[sel_q]   <= tmp_q;
					end
				end
				tpgc_pkg::ST_RES_SAT: begin
					count_q[sel_q] <= acc_sat;
				end
				tpgc_pkg::ST_SW_FINISH: begin
					dir_q[!sel_q] <= tpgc_pkg::DIR_DOWN;
					marker_q      <= sel_q ? tpgc_pkg::RUN_LEFT : tpgc_pkg::RUN_RIGHT;
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Scratch registers of the shared unit
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			tpgc_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					cmd_q <= cmd;
				end
			end
			tpgc_pkg::ST_DECODE: begin
				// Ticks and resets walk left then right; a switch works on the mover.
				sel_q <= (cmd_q.command == tpgc_pkg::CMD_TICK
					|| cmd_q.command == tpgc_pkg::CMD_RESET) ? 1'b0 : act_right;
			end
			tpgc_pkg::ST_TICK: begin
				sel_q <= 1'b1;
			end
			tpgc_pkg::ST_INIT_LOAD: begin
				acc_q    <= AW'(main_q[sel_q]);
				mcand_q  <= AW'(inc);
				mplier_q <= init_mult;
				step_q   <= '0;
			end
			tpgc_pkg::ST_INIT_MUL, tpgc_pkg::ST_RES_MUL: begin
				if (mplier_q[0]) begin
					acc_q <= alu_sum;
				end
				mcand_q  <= mcand_q <<< 1;
				mplier_q <= mplier_q >> 1;
				step_q   <= step_q + SW'(1);
			end
			tpgc_pkg::ST_INIT_SAT: begin
				sel_q <= 1'b1;
			end
			tpgc_pkg::ST_SW_CHECK: begin
				rem_q  <= '0;
				quo_q  <= DW'(cur);
				step_q <= '0;
			end
			tpgc_pkg::ST_SW_ADD: begin
				tmp_q <= sum_sat;
			end
			tpgc_pkg::ST_DIV: begin
				// Restoring division, one quotient bit a cycle.
				if (!alu_sum[AW-1]) begin
					rem_q <= alu_sum[DW:0];
					quo_q <= {quo_q[DW-2:0], 1'b1};
				end else begin
					rem_q <= div_shift;
					quo_q <= {quo_q[DW-2:0], 1'b0};
				end
				step_q <= step_q + SW'(1);
			end
			tpgc_pkg::ST_DIV_CHK: begin
				// Restore the end of the current period: length * (periods used + 1).
				acc_q    <= '0;
				mcand_q  <= AW'(inc);
				mplier_q <= quo_q[MW-1:0] + MW'(1);
				step_q   <= '0;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == tpgc_pkg::ST_DONE && out_go) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tpgc_pkg::ST_DONE && out_go) begin
			res_q.left_time     <= TW'(count_q[0]);
			res_q.right_time    <= TW'(count_q[1]);
			res_q.running_side  <= marker_q;
			res_q.left_flagged  <= count_q[0][CNT_W-1];
			res_q.right_flagged <= count_q[1][CNT_W-1];
			res_q.state_changed <= changed_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

### rtl/tpgc_checker.sv
// ----------------------------------------------------------------------------
// tpgc_checker: port-level checks of the game clock
// Watches the command and result channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module tpgc_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           cmd_valid,
	input wire logic           cmd_ready,
	input wire logic           res_valid,
	input wire logic           res_ready,
	input wire tpgc_pkg::res_t res
);

	// A held result keeps its value until the transfer.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// One command at a time: the block is busy right after an accept.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command accepted while previous one in work");

	// Flags follow the sign of the reported times.
	a_left_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.left_flagged == res.left_time[tpgc_pkg::TIME_W-1])
		else $error("left flag disagrees with left time");

	a_right_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.right_flagged == res.right_time[tpgc_pkg::TIME_W-1])
		else $error("right flag disagrees with right time");

endmodule

bind two_player_game_clock_core tpgc_checker u_tpgc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

`default_nettype wire
